@@ hw/rtl/wma_pkg.sv @@
// shared constants and types for the weighted moving average block
// no dependencies
package wma_pkg;

  localparam int SAMPLE_BITS    = 32;
  localparam int WIN_BITS       = 9;
  localparam int MAX_WINDOW_DEF = 256;

  localparam logic [WIN_BITS-1:0] WIN_RESET = 9'd22;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WIN_BITS-1:0]           win_t;

endpackage

@@ hw/rtl/wma_stream_if.sv @@
// valid/ready stream interfaces for sample beats and average beats
// depends on wma_pkg
interface wma_in_if import wma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    series_start;

  modport source (output valid, sample, series_start, input ready);
  modport sink   (input valid, sample, series_start, output ready);
endinterface

interface wma_out_if import wma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t average;
  logic    average_valid;

  modport source (output valid, average, average_valid, input ready);
  modport sink   (input valid, average, average_valid, output ready);
endinterface

@@ hw/rtl/weighted_moving_average.sv @@
// Linear weighted moving average of signed Q16.16 samples. Each input beat
// yields one output beat; the newest of the last n samples (n from cfg,
// 0 taken as 1, clamped to MAX_WINDOW) has weight n, the oldest weight 1,
// and the result is the weighted sum over n(n+1)/2, truncated toward zero.
// Until n samples have arrived since a series start or a cfg write the
// beat carries average_valid = 0 and average = 0. One sample is handled
// at a time: a valid average goes through the one-bit-per-cycle divider,
// while a not-yet-valid beat skips the divider. Sample history sits in a
// single-port-read, single-port-write memory of MAX_WINDOW entries that
// needs no clearing after reset.
// A cfg write clears the sums and restarts the series.
// depends on wma_pkg, wma_stream_if and wma_div
module weighted_moving_average import wma_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  win_t      cfg_wr_data,
  wma_in_if.sink    in_ch,
  wma_out_if.source out_ch
);

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int CW   = (NW > WIN_BITS) ? NW : WIN_BITS;
  localparam int IW   = NW + 1;
  localparam int DB   = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
  localparam int PB   = SAMPLE_BITS + AW + 1;
  localparam int MB   = SAMPLE_BITS + NW + 1;
  localparam int WB_A = SAMPLE_BITS + 2 * AW;
  localparam int WB   = (WB_A > MB) ? WB_A : MB;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DST  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  win_t                 wl_r, wl_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [NW-1:0]        fill_r, fill_nxt;
  logic signed [PB-1:0] psum_r, psum_nxt;
  logic signed [WB-1:0] wsum_r, wsum_nxt;
  logic                 out_valid_r, out_valid_nxt;

  sample_t              s_r, s_nxt;
  logic signed [MB-1:0] prod_r, prod_nxt;
  logic [DB-1:0]        dvs_r, dvs_nxt;
  logic                 vld_r, vld_nxt;
  sample_t              res_r, res_nxt;
  sample_t              out_avg_r, out_avg_nxt;
  logic                 out_flag_r, out_flag_nxt;
  sample_t              rd_r;

  sample_t              hist_mem [MAX_WINDOW];

  logic                 in_acc;
  logic [CW-1:0]        wl_ext;
  logic [NW-1:0]        n_c;
  logic [NW:0]          n_p1;
  logic [2*NW:0]        nn;
  logic                 grow;
  logic [NW-1:0]        mult;
  logic [AW-1:0]        wp_eff;
  logic [IW-1:0]        old_sum;
  logic [IW-1:0]        old_idx;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wp_inc;
  logic                 mem_we;
  logic                 div_start;
  logic                 div_done;
  sample_t              div_q;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign wl_ext = CW'(wl_r);
  assign n_c    = (wl_r == '0) ? NW'(1)
                : (wl_ext > CW'(MAX_WINDOW)) ? NW'(MAX_WINDOW) : NW'(wl_ext);
  assign n_p1   = {1'b0, n_c} + (NW+1)'(1);
  assign nn     = (2*NW+1)'(n_c) * (2*NW+1)'(n_p1);
  assign grow   = (fill_r < n_c);
  assign mult   = grow ? (fill_r + NW'(1)) : n_c;

  // oldest entry sits n places behind the write pointer
  assign wp_eff  = in_ch.series_start ? '0 : wp_r;
  assign old_sum = IW'(wp_eff) + IW'(MAX_WINDOW) - IW'(n_c);
  assign old_idx = (old_sum >= IW'(MAX_WINDOW)) ? old_sum - IW'(MAX_WINDOW) : old_sum;
  assign rd_addr = old_idx[AW-1:0];
  assign wp_inc  = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);

  assign mem_we    = (state_r == S_ACC);
  assign div_start = (state_r == S_DST);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= s_r;
    end
    if (in_acc) begin
      rd_r <= hist_mem[rd_addr];
    end
  end

  wma_div #(
    .DIVIDEND_BITS (WB),
    .DIVISOR_BITS  (DB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wsum_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    psum_nxt      = psum_r;
    wsum_nxt      = wsum_r;
    out_valid_nxt = out_valid_r;
    s_nxt         = s_r;
    prod_nxt      = prod_r;
    dvs_nxt       = dvs_r;
    vld_nxt       = vld_r;
    res_nxt       = res_r;
    out_avg_nxt   = out_avg_r;
    out_flag_nxt  = out_flag_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          s_nxt     = in_ch.sample;
          state_nxt = S_MUL;
          if (in_ch.series_start) begin
            wp_nxt   = '0;
            fill_nxt = '0;
            psum_nxt = '0;
            wsum_nxt = '0;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = MB'(s_r) * MB'($signed({1'b0, mult}));
        dvs_nxt   = DB'(nn >> 1);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (grow) begin
          fill_nxt = fill_r + NW'(1);
          psum_nxt = psum_r + PB'(s_r);
          wsum_nxt = wsum_r + WB'(prod_r);
          vld_nxt  = ((fill_r + NW'(1)) >= n_c);
        end else begin
          psum_nxt = psum_r + PB'(s_r) - PB'(rd_r);
          wsum_nxt = wsum_r - WB'(psum_r) + WB'(prod_r);
          vld_nxt  = 1'b1;
        end
        wp_nxt = wp_inc;
        if (grow && ((fill_r + NW'(1)) < n_c)) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DST;
        end
      end
      S_DST: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = div_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = res_r;
          out_flag_nxt  = vld_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      wl_nxt   = cfg_wr_data;
      wp_nxt   = '0;
      fill_nxt = '0;
      psum_nxt = '0;
      wsum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= WIN_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      psum_r      <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      psum_r      <= psum_nxt;
      wsum_r      <= wsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    prod_r     <= prod_nxt;
    dvs_r      <= dvs_nxt;
    vld_r      <= vld_nxt;
    res_r      <= res_nxt;
    out_avg_r  <= out_avg_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.average       = out_avg_r;
  assign out_ch.average_valid = out_flag_r;

endmodule

@@ hw/rtl/wma_div.sv @@
// signed by unsigned restoring divider, one quotient bit per cycle
// depends on wma_pkg
module wma_div import wma_pkg::*; #(
  parameter int DIVIDEND_BITS = 48,
  parameter int DIVISOR_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [DIVIDEND_BITS-1:0] dividend,
  input  logic        [DIVISOR_BITS-1:0]  divisor,
  output logic                            done,
  output sample_t                         quotient
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

  logic                     busy_r;
  logic                     done_r;
  logic [CNT_BITS-1:0]      cnt_r;
  logic                     neg_r;
  logic [DIVISOR_BITS-1:0]  rem_r;
  logic [DIVISOR_BITS-1:0]  dvs_r;
  logic [SAMPLE_BITS-1:0]   lo_r;

  logic [DIVIDEND_BITS-1:0] mag;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  assign mag   = dividend[DIVIDEND_BITS-1] ? DIVIDEND_BITS'(-dividend)
                                           : DIVIDEND_BITS'(dividend);
  assign trial = {rem_r, lo_r[SAMPLE_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(SAMPLE_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient magnitude fits in sample width, so the upper dividend bits
  // start below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIVIDEND_BITS-1];
      dvs_r <= divisor;
      rem_r <= DIVISOR_BITS'(mag >> SAMPLE_BITS);
      lo_r  <= mag[SAMPLE_BITS-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      lo_r  <= {lo_r[SAMPLE_BITS-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? sample_t'(-lo_r) : sample_t'(lo_r);

endmodule

@@ hw/rtl/wma_chk.sv @@
// port-level assertions for the weighted moving average top level
// depends on wma_pkg; bound to weighted_moving_average below
module wma_chk import wma_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input sample_t out_average,
  input logic    out_average_valid
);

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average)
                                && $stable(out_average_valid))
    else $error("stalled output beat changed");

  a_zero_when_filling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_average_valid |-> out_average == '0)
    else $error("average not zero while window is filling");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");

endmodule

bind weighted_moving_average wma_chk u_wma_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_average       (out_ch.average),
  .out_average_valid (out_ch.average_valid)
);
